### rtl/core/cfcs_pkg.sv
// Shared constants, types and state codes for the cumulative fitness cutoff selector.
package cfcs_pkg;

   localparam int POP_SIZE    = 64;
   localparam int IDX_W       = $clog2(POP_SIZE);
   localparam int CNT_W       = $clog2(POP_SIZE + 1);
   localparam int FIT_W       = 32;
   localparam int SUM_W       = 40;
   localparam int FRAC_W      = 17;
   localparam int FRAC_SHIFT  = 16;
   localparam int LIMIT_W     = FRAC_W + SUM_W;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [FRAC_W-1:0] FRAC_RESET   = FRAC_W'(32768);
   localparam logic [FIT_W-1:0]  LOWEST_RESET = {1'b0, {(FIT_W-1){1'b1}}};

   // One finished population, handed from the loader to the walker.
   typedef struct packed {
      logic [CNT_W-1:0]        count;
      logic signed [FIT_W-1:0] lowest;
      logic [SUM_W-1:0]        excess;
   } job_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      logic [FIT_W-1:0] data;
   } ram_wr_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
   } ram_rd_type;

   typedef enum logic [1:0] {
      WS_IDLE,
      WS_LIMIT,
      WS_WALK
   } walk_state_type;

endpackage

### rtl/core/cfcs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cfcs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/cfcs_front.sv
// Loader: stores each fitness word, tracks count, minimum and sum, and queues a job at the end.
module cfcs_front import cfcs_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  logic signed [FIT_W-1:0] fitness_value,
   input  logic                    is_final,
   output ram_wr_type              ram_wr,
   output logic                    push,
   output job_type                 push_job,
   output logic                    front_busy
);

   logic [CNT_W-1:0]        count_ff, count_in;
   logic signed [FIT_W-1:0] lowest_ff, lowest_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic signed [SUM_W-1:0] prod_ff, prod_in;
   logic                    fin1_ff, fin1_in;
   logic                    fin2_ff, fin2_in;
   logic                    room;

   assign room = count_ff < CNT_W'(POP_SIZE);

   always_comb begin
      count_in  = count_ff;
      lowest_in = lowest_ff;
      sum_in    = sum_ff;
      if (fin2_ff) begin
         count_in  = '0;
         lowest_in = LOWEST_RESET;
         sum_in    = '0;
      end else if (accept && room) begin
         count_in = count_ff + CNT_W'(1);
         if (fitness_value < lowest_ff) begin
            lowest_in = fitness_value;
         end
         sum_in = sum_ff + SUM_W'(fitness_value);
      end
   end

   assign fin1_in = accept && is_final;
   assign fin2_in = fin1_ff;
   // The count is never zero here, since the final word itself is counted or the store is full.
   assign prod_in = $signed({1'b0, count_ff}) * SUM_W'(lowest_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         lowest_ff <= LOWEST_RESET;
         sum_ff    <= '0;
         fin1_ff   <= 1'b0;
         fin2_ff   <= 1'b0;
      end else begin
         count_ff  <= count_in;
         lowest_ff <= lowest_in;
         sum_ff    <= sum_in;
         fin1_ff   <= fin1_in;
         fin2_ff   <= fin2_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign ram_wr.en   = accept && room;
   assign ram_wr.addr = count_ff[IDX_W-1:0];
   assign ram_wr.data = fitness_value;

   assign push            = fin2_ff;
   assign push_job.count  = count_ff;
   assign push_job.lowest = lowest_ff;
   assign push_job.excess = SUM_W'(sum_ff - prod_ff);

   assign front_busy = fin1_ff || fin2_ff;

endmodule

### rtl/core/cfcs_queue.sv
// Short job queue between the loader and the walker.
module cfcs_queue import cfcs_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output job_type pop_job,
   output logic    empty,
   output logic    full
);

   job_type            slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  fill_ff, fill_in;
   logic               do_push, do_pop;

   assign empty   = fill_ff == '0;
   assign full    = fill_ff == QCNT_W'(QUEUE_DEPTH);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   assign wr_ptr_in = !do_push ? wr_ptr_ff :
                      (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
   assign rd_ptr_in = !do_pop ? rd_ptr_ff :
                      (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);

   always_comb begin
      fill_in = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   assign pop_job = slot_ff[rd_ptr_ff];

endmodule

### rtl/core/cfcs_back.sv
// Walker: forms the cutoff limit, then reads the stored words in order and emits results.
module cfcs_back import cfcs_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic [FRAC_W-1:0] keep_fraction,
   input  logic              q_empty,
   input  job_type           q_job,
   output logic              pop,
   output ram_rd_type        ram_rd,
   input  logic [FIT_W-1:0]  ram_rdata,
   output logic              back_busy,
   output logic              rsp_valid,
   output logic [5:0]        rsp_chosen_index,
   output logic [FIT_W-1:0]  rsp_chosen_fitness,
   output logic              rsp_run_end
);

   walk_state_type     state_ff, state_in;
   job_type            job_ff;
   logic [LIMIT_W-1:0] limit_ff;
   logic [CNT_W-1:0]   rd_idx_ff, rd_idx_in;
   logic [CNT_W-1:0]   data_idx_ff;
   logic               data_vld_ff, data_vld_in;
   logic [SUM_W-1:0]   acc_ff, acc_in;
   logic               first_ff;
   logic               rd_issue;
   logic [FIT_W:0]     diff;
   logic               stop;
   logic               last_idx;
   logic               finish;
   logic               rsp_valid_ff;
   logic [5:0]         rsp_index_ff;
   logic [FIT_W-1:0]   rsp_fitness_ff;
   logic               rsp_end_ff;

   // Excess of this word over the minimum; never negative.
   assign diff     = {ram_rdata[FIT_W-1], ram_rdata} - {job_ff.lowest[FIT_W-1], job_ff.lowest};
   assign acc_in   = acc_ff + SUM_W'(diff);
   assign stop     = ({1'b0, acc_in, {FRAC_SHIFT{1'b0}}} > limit_ff) && !first_ff;
   assign last_idx = (data_idx_ff + CNT_W'(1)) == job_ff.count;
   assign finish   = data_vld_ff && (stop || last_idx);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         WS_IDLE: begin
            if (!q_empty) begin
               state_in = WS_LIMIT;
            end
         end
         WS_LIMIT: begin
            state_in = WS_WALK;
         end
         WS_WALK: begin
            if (finish) begin
               state_in = WS_IDLE;
            end
         end
         default: begin
            state_in = WS_IDLE;
         end
      endcase
   end

   always_comb begin
      pop      = 1'b0;
      rd_issue = 1'b0;
      unique case (state_ff)
         WS_IDLE: begin
            pop = !q_empty;
         end
         WS_LIMIT: begin
         end
         WS_WALK: begin
            rd_issue = rd_idx_ff < job_ff.count;
         end
         default: begin
         end
      endcase
   end

   assign back_busy = state_ff != WS_IDLE;

   assign ram_rd.en   = rd_issue;
   assign ram_rd.addr = rd_idx_ff[IDX_W-1:0];

   assign rd_idx_in = (state_ff == WS_LIMIT) ? '0 :
                      rd_issue ? rd_idx_ff + CNT_W'(1) : rd_idx_ff;
   // A read already in flight when the walk stops is dropped.
   assign data_vld_in = rd_issue && !finish;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= WS_IDLE;
         data_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         first_ff     <= 1'b1;
      end else begin
         state_ff     <= state_in;
         data_vld_ff  <= data_vld_in;
         rsp_valid_ff <= data_vld_ff;
         if (state_ff == WS_LIMIT) begin
            first_ff <= 1'b1;
         end else if (data_vld_ff) begin
            first_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         job_ff <= q_job;
      end
      if (state_ff == WS_LIMIT) begin
         limit_ff <= LIMIT_W'(keep_fraction) * LIMIT_W'(job_ff.excess);
         acc_ff   <= '0;
      end else if (data_vld_ff) begin
         acc_ff <= acc_in;
      end
      rd_idx_ff   <= rd_idx_in;
      data_idx_ff <= rd_idx_ff;
      if (data_vld_ff) begin
         rsp_index_ff   <= 6'(data_idx_ff);
         rsp_fitness_ff <= ram_rdata;
         rsp_end_ff     <= finish;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_chosen_index   = rsp_index_ff;
   assign rsp_chosen_fitness = rsp_fitness_ff;
   assign rsp_run_end        = rsp_end_ff;

endmodule

### rtl/core/cumulative_fitness_cutoff_select.sv
// Top level of the cumulative fitness cutoff selector.
//
// Usage: a population of up to 64 fitness words is loaded one word per cycle
// through start/busy; a word is taken at a clock edge with start high and busy
// low. Words beyond the 64th are dropped. The word with req_is_final set is
// stored like the others unless the store is full, and closes the population.
// After the final word the loader registers the product of count and minimum,
// forms the total excess and queues the job; the walker then pops it, forms the
// cutoff product in WS_LIMIT and starts reading the fitness RAM, one word per
// cycle. Results come one per cycle, each with rsp_valid high for exactly one
// cycle. The last result of the population carries rsp_run_end. The RAM's
// registered read port sets that pace. busy stays high from the final word
// until the cycle that shows the last result.
// The receiver cannot stall; every result must be taken as it is shown.
// csr_we writes keep_fraction (unsigned Q1.16) at any edge; it is meant to be
// written while busy is low. Reset restores keep_fraction to one half and
// clears the population state; the RAM needs no clearing pass.
module cumulative_fitness_cutoff_select import cfcs_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic signed [FIT_W-1:0] req_fitness_value,
   input  logic                    req_is_final,
   output logic                    rsp_valid,
   output logic [5:0]              rsp_chosen_index,
   output logic signed [FIT_W-1:0] rsp_chosen_fitness,
   output logic                    rsp_run_end,
   input  logic                    csr_we,
   input  logic [FRAC_W-1:0]       csr_wdata
);

   logic [FRAC_W-1:0] keep_fraction_ff;
   logic              accept;
   ram_wr_type        ram_wr;
   ram_rd_type        ram_rd;
   logic [FIT_W-1:0]  ram_rdata;
   logic              push;
   job_type           push_job;
   logic              pop;
   job_type           q_job;
   logic              q_empty;
   logic              q_full;
   logic              front_busy;
   logic              back_busy;
   logic [FIT_W-1:0]  rsp_fitness_raw;

   always_ff @(posedge clock) begin
      if (reset) begin
         keep_fraction_ff <= FRAC_RESET;
      end else if (csr_we) begin
         keep_fraction_ff <= csr_wdata;
      end
   end

   assign accept = start && !busy;
   assign busy   = front_busy || !q_empty || back_busy;

   cfcs_front u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .fitness_value (req_fitness_value),
      .is_final      (req_is_final),
      .ram_wr        (ram_wr),
      .push          (push),
      .push_job      (push_job),
      .front_busy    (front_busy)
   );

   cfcs_ram #(
      .WIDTH (FIT_W),
      .DEPTH (POP_SIZE)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr.en),
      .wr_addr (ram_wr.addr),
      .wr_data (ram_wr.data),
      .rd_en   (ram_rd.en),
      .rd_addr (ram_rd.addr),
      .rd_data (ram_rdata)
   );

   cfcs_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .pop_job  (q_job),
      .empty    (q_empty),
      .full     (q_full)
   );

   cfcs_back u_back (
      .clock              (clock),
      .reset              (reset),
      .keep_fraction      (keep_fraction_ff),
      .q_empty            (q_empty),
      .q_job              (q_job),
      .pop                (pop),
      .ram_rd             (ram_rd),
      .ram_rdata          (ram_rdata),
      .back_busy          (back_busy),
      .rsp_valid          (rsp_valid),
      .rsp_chosen_index   (rsp_chosen_index),
      .rsp_chosen_fitness (rsp_fitness_raw),
      .rsp_run_end        (rsp_run_end)
   );

   assign rsp_chosen_fitness = $signed(rsp_fitness_raw);

   // A finished population is never queued on top of a full queue.
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_full)
      else $error("job queued while queue full");

   // A word taken while idle cannot produce a result in the very next cycle.
   a_no_result_after_load: assert property (@(posedge clock) disable iff (reset)
      accept |=> !rsp_valid)
      else $error("result right after a loaded word");

   // The last result of a population is followed by a gap.
   a_gap_after_run_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_run_end) |=> !rsp_valid)
      else $error("result after end of run");

   // Busy only rises after a word was taken.
   a_busy_rises_on_load: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(accept))
      else $error("busy rose without a loaded word");

endmodule

### tb/cfcs_checker.sv
// Scoreboard for the cutoff selector: tracks each population, predicts its picks and checks them.
module cfcs_checker import cfcs_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic                    busy,
   input  logic signed [FIT_W-1:0] req_fitness_value,
   input  logic                    req_is_final,
   input  logic                    rsp_valid,
   input  logic [5:0]              rsp_chosen_index,
   input  logic signed [FIT_W-1:0] rsp_chosen_fitness,
   input  logic                    rsp_run_end,
   input  logic                    csr_we,
   input  logic [FRAC_W-1:0]       csr_wdata,
   output int                      fail_count,
   output int                      picks_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [IDX_W-1:0]        index;
      logic signed [FIT_W-1:0] fitness;
      logic                    run_end;
   } pick_type;

   pick_type                picks_due[$];
   logic [FRAC_W-1:0]       keep_share;
   logic signed [FIT_W-1:0] fit_mem [POP_SIZE];
   int                      pop_count;
   longint                  pop_lowest;
   longint                  pop_total;
   int                      mismatches = 0;

   task automatic clear_population();
      pop_count  = 0;
      pop_lowest = 64'sd2147483647;
      pop_total  = 0;
   endtask

   // Walks the stored population and queues every chromosome the cutoff keeps.
   task automatic close_population();
      logic [63:0] excess_total;
      logic [63:0] cutoff;
      logic [63:0] running;
      pick_type    p;
      int          n;
      excess_total = 64'(pop_total - longint'(pop_count) * pop_lowest);
      cutoff       = excess_total * 64'(keep_share);
      running      = '0;
      n            = 0;
      for (int i = 0; i < pop_count; i++) begin
         running   = running + 64'(longint'(fit_mem[i]) - pop_lowest);
         n++;
         p.index   = IDX_W'(i);
         p.fitness = fit_mem[i];
         p.run_end = 1'b0;
         picks_due.push_back(p);
         // The comparison is exact: the sum is scaled up rather than the cutoff down.
         if ((running << FRAC_SHIFT) > cutoff && n > 1) begin
            break;
         end
      end
      picks_due[picks_due.size() - 1].run_end = 1'b1;
      clear_population();
   endtask

   always @(posedge clock) begin
      pick_type want;
      if (reset) begin
         keep_share = FRAC_RESET;
         picks_due.delete();
         clear_population();
      end else begin
         if (rsp_valid) begin
            if (picks_due.size() == 0) begin
               if (mismatches < 10) begin
                  $display("%0t: unexpected result index %0d fitness %0d run_end %0b", $time,
                           rsp_chosen_index, rsp_chosen_fitness, rsp_run_end);
               end
               mismatches++;
            end else begin
               want = picks_due.pop_front();
               if (rsp_chosen_index !== want.index || rsp_chosen_fitness !== want.fitness ||
                   rsp_run_end !== want.run_end) begin
                  if (mismatches < 10) begin
                     $display("%0t: result mismatch: expected index %0d fitness %0d run_end %0b,",
                              $time, want.index, want.fitness, want.run_end);
                     $display("   got index %0d fitness %0d run_end %0b",
                              rsp_chosen_index, rsp_chosen_fitness, rsp_run_end);
                  end
                  mismatches++;
               end
            end
         end
         if (csr_we) begin
            keep_share = csr_wdata;
         end
         if (start && !busy) begin
            // A full store drops the word, but a final word still starts the walk.
            if (pop_count < POP_SIZE) begin
               fit_mem[pop_count] = req_fitness_value;
               pop_count++;
               if (req_fitness_value < pop_lowest) begin
                  pop_lowest = req_fitness_value;
               end
               pop_total += req_fitness_value;
            end
            if (req_is_final) begin
               close_population();
            end
         end
      end
      fail_count    = mismatches;
      picks_pending = picks_due.size();
   end

endmodule

### tb/tb_cumulative_fitness_cutoff_select.sv
// Testbench top for the cumulative fitness cutoff selector: stimulus, watchdog and verdict.
module tb_cumulative_fitness_cutoff_select;
   timeunit 1ns;
   timeprecision 1ps;
   import cfcs_pkg::*;

   localparam int STALL_LIMIT = 5000;
   localparam logic signed [FIT_W-1:0] FIT_MAX = 32'sh7fff_ffff;
   localparam logic signed [FIT_W-1:0] FIT_MIN = 32'sh8000_0000;
   localparam logic [FRAC_W-1:0] SHARE_ONE = FRAC_W'(65536);
   localparam logic [FRAC_W-1:0] SHARE_TOP = FRAC_W'(131071);

   typedef enum int {SPREAD_FULL, SPREAD_NEAR, SPREAD_FLAT, SPREAD_EDGE} spread_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   logic                    busy;
   logic signed [FIT_W-1:0] req_fitness_value = '0;
   logic                    req_is_final = 1'b0;
   logic                    rsp_valid;
   logic [5:0]              rsp_chosen_index;
   logic signed [FIT_W-1:0] rsp_chosen_fitness;
   logic                    rsp_run_end;
   logic                    csr_we = 1'b0;
   logic [FRAC_W-1:0]       csr_wdata = '0;
   int                      fail_count;
   int                      picks_pending;
   int                      idle_pct = 0;
   int                      stall_cycles = 0;
   int                      idle_plan[4] = '{0, 72, 0, 6};
   logic signed [FIT_W-1:0] pop_words[$];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   cumulative_fitness_cutoff_select DUT (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_fitness_value  (req_fitness_value),
      .req_is_final       (req_is_final),
      .rsp_valid          (rsp_valid),
      .rsp_chosen_index   (rsp_chosen_index),
      .rsp_chosen_fitness (rsp_chosen_fitness),
      .rsp_run_end        (rsp_run_end),
      .csr_we             (csr_we),
      .csr_wdata          (csr_wdata)
   );

   cfcs_checker selection_check (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_fitness_value  (req_fitness_value),
      .req_is_final       (req_is_final),
      .rsp_valid          (rsp_valid),
      .rsp_chosen_index   (rsp_chosen_index),
      .rsp_chosen_fitness (rsp_chosen_fitness),
      .rsp_run_end        (rsp_run_end),
      .csr_we             (csr_we),
      .csr_wdata          (csr_wdata),
      .fail_count         (fail_count),
      .picks_pending      (picks_pending)
   );

   // Called and left at a falling edge; busy read after the rising edge is its pre-edge value.
   task automatic send_word(input logic signed [FIT_W-1:0] f, input logic fin);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start             <= 1'b1;
      req_fitness_value <= f;
      req_is_final      <= fin;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   task automatic send_population();
      foreach (pop_words[i]) begin
         send_word(pop_words[i], i == pop_words.size() - 1);
      end
      pop_words.delete();
   endtask

   // Holds the sender off until every predicted pick has come back and the block is idle.
   task automatic drain();
      start <= 1'b0;
      do @(negedge clock); while (picks_pending != 0 || busy);
   endtask

   task automatic write_share(input logic [FRAC_W-1:0] value);
      drain();
      repeat (8) @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   function automatic logic signed [FIT_W-1:0] random_fitness(input spread_type spread,
                                                              input logic signed [FIT_W-1:0] base);
      case (spread)
         SPREAD_FULL: return FIT_W'($urandom);
         SPREAD_NEAR: return base + FIT_W'($urandom_range(40)) - 20;
         SPREAD_FLAT: return base;
         default: begin
            case ($urandom_range(3))
               0: return FIT_MAX;
               1: return FIT_MIN;
               2: return '0;
               default: return -1;
            endcase
         end
      endcase
   endfunction

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || csr_we) begin
         stall_cycles <= 0;
      end else if (stall_cycles == STALL_LIMIT) begin
         $display("[cumulative_fitness_cutoff_select] ERROR");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      int                      size;
      int                      sent;
      spread_type              spread;
      logic signed [FIT_W-1:0] base;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed populations under the reset share of one half.
      pop_words = '{32'sd5, -32'sd3, 32'sd10, 32'sd7};
      send_population();
      pop_words = '{FIT_MIN};
      send_population();
      pop_words = '{FIT_MAX, FIT_MAX, FIT_MAX};
      send_population();
      pop_words = '{FIT_MAX, FIT_MIN};
      send_population();
      write_share('0);
      pop_words = '{32'sd1, 32'sd2, 32'sd3};
      send_population();
      write_share(SHARE_ONE);
      pop_words = '{32'sd0, 32'sd100, -32'sd100, 32'sd50};
      send_population();
      // A share above one can never be exceeded, so every word comes back.
      write_share(SHARE_TOP);
      pop_words = '{32'sd9, 32'sd1, 32'sd4};
      send_population();
      write_share(FRAC_RESET);

      // Overfill the store: the words past the 64th, the final one too, are dropped.
      base = FIT_W'($urandom_range(1000));
      repeat (66) pop_words.push_back(random_fitness(SPREAD_NEAR, base));
      send_population();

      for (int ph = 0; ph < 4; ph++) begin
         idle_pct = idle_plan[ph];
         sent     = 0;
         while (sent < 10) begin
            if ($urandom_range(2) == 0) begin
               case ($urandom_range(4))
                  0: write_share('0);
                  1: write_share(SHARE_ONE);
                  2: write_share(SHARE_TOP);
                  3: write_share(FRAC_W'($urandom_range(65536)));
                  default: write_share(FRAC_W'($urandom_range(131071)));
               endcase
            end
            size   = $urandom_range(1, 8);
            spread = spread_type'($urandom_range(3));
            base   = ($urandom_range(1) == 0) ? FIT_W'($urandom) : FIT_W'($urandom_range(200)) - 100;
            repeat (size) pop_words.push_back(random_fitness(spread, base));
            send_population();
            sent += size;
         end
         drain();
      end

      drain();
      repeat (20) @(posedge clock);
      if (fail_count == 0 && picks_pending == 0) begin
         $display("[cumulative_fitness_cutoff_select] OK");
      end else begin
         $display("[cumulative_fitness_cutoff_select] ERROR");
      end
      $finish;
   end

endmodule
